// ===== hw/rtl/pvt_pkg.sv =====
// Shared types and codes for the polyphonic voice table.
// Used by pvt_cell and polyphonic_voice_table; depends on nothing.
package pvt_pkg;

  localparam int TIME_W = 31;
  localparam int TONE_W = 24;
  localparam int GAIN_W = 16;
  localparam int REL_W  = 16;
  localparam int STOP_W = 32;

  localparam logic [STOP_W-1:0] STOP_HELD = '1;
  localparam logic [REL_W-1:0]  REL_RESET = 16'd35;

  typedef enum logic [1:0] {
    KIND_PLAY = 2'd0,
    KIND_STOP = 2'd1,
    KIND_TICK = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_ADDED      = 3'd0,
    STAT_ADD_EVICT  = 3'd1,
    STAT_STOPPED    = 3'd2,
    STAT_NO_MATCH   = 3'd3,
    STAT_TICK_DONE  = 3'd4,
    STAT_READ_OK    = 3'd5,
    STAT_READ_EMPTY = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_EVICT,
    OP_STOP,
    OP_MARK,
    OP_COMPACT,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COMPACT,
    ST_ROTATE,
    ST_EMIT
  } state_t;

  // one voice entry as it moves along the chain
  typedef struct packed {
    logic              valid;
    logic              dead;
    logic              held;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
    logic [TONE_W-1:0] tone;
    logic [GAIN_W-1:0] gain;
    logic [TIME_W-1:0] deadline;
  } voice_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t          op;
    voice_t            fresh;
    logic [TONE_W-1:0] tone;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] stop_stamp;
    logic [TIME_W-1:0] deadline;
  } ctrl_t;

endpackage

// ===== hw/rtl/pvt_cell.sv =====
// One entry of the voice chain: holds a voice and takes its upper neighbour on a shift.
// Depends on pvt_pkg.
module pvt_cell
  import pvt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ctrl_t  ctrl,
  input  logic   load_sel,
  input  voice_t next_in,
  input  logic   found_in,
  input  logic   hole_in,
  output logic   found_out,
  output logic   hole_out,
  output logic   hit,
  output voice_t q
);

  voice_t q_next;
  logic   match;

  always_comb begin
    match     = q.valid & q.held & (q.tone == ctrl.tone);
    hit       = match & ~found_in;
    found_out = found_in | match;
    // a cell at or above the first dead entry pulls from its neighbour
    hole_out  = hole_in | (q.valid & q.dead);
    q_next    = q;
    unique case (ctrl.op)
      OP_HOLD:    q_next = q;
      OP_APPEND:  if (load_sel) q_next = ctrl.fresh;
      OP_EVICT:   q_next = next_in;
      OP_ROTATE:  q_next = next_in;
      OP_STOP: begin
        if (hit) begin
          q_next.held     = 1'b0;
          q_next.stop     = ctrl.stop_stamp;
          q_next.deadline = ctrl.deadline;
        end
      end
      OP_MARK:    q_next.dead = q.valid & ~q.held & (q.deadline == ctrl.now);
      OP_COMPACT: if (hole_out) q_next = next_in;
      default:    q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
      q.dead  <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

endmodule

// ===== hw/rtl/polyphonic_voice_table.sv =====
// Polyphonic voice table: age-ordered chain of VOICES cells, oldest note in cell 0.
// Play and stop: the request is executed in ST_EXEC and its result registered in ST_EMIT.
// Tick and read: ST_EXEC is followed by one pass of shifts along the cell chain before ST_EMIT;
// a stalled result holds ST_EMIT, and no new request is taken until the table is idle again.
// Synchronous reset empties the table and sets the release length to 35.
module polyphonic_voice_table
  import pvt_pkg::*;
#(
  parameter int VOICES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // now_time[30:0], note_tone[54:31], note_gain[70:55], read_slot[74:71], zero fill
  input  logic [79:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slot[3:0], active_count[8:4], removed_count[13:9], entry_start[44:14],
  // entry_stop[76:45], entry_tone[100:77], entry_gain[116:101], zero fill
  output logic [119:0] m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser
);

  localparam int CW    = $clog2(VOICES + 1);
  localparam int CMP_W = (CW > 4) ? CW : 4;
  localparam int OW    = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] FULL_COUNT = CW'(VOICES);
  localparam logic [CW-1:0] LAST_STEP  = CW'(VOICES - 1);
  localparam logic [3:0]    SLOT_LAST  = 4'(VOICES - 1);

  state_t   state, state_next;
  ctrl_t    ctrl;
  cell_op_t op_sel;

  logic [REL_W-1:0]  release_len;
  logic [CW-1:0]     count;
  logic [CW-1:0]     step;
  logic [CW-1:0]     removed;

  kind_t             req_kind;
  logic [TIME_W-1:0] req_now;
  logic [TONE_W-1:0] req_tone;
  logic [GAIN_W-1:0] req_gain;
  logic [3:0]        req_rslot;

  status_t           res_status;
  logic [3:0]        res_slot;
  logic [TIME_W-1:0] res_start;
  logic [STOP_W-1:0] res_stop;
  logic [TONE_W-1:0] res_tone;
  logic [GAIN_W-1:0] res_gain;

  voice_t cells [VOICES];
  voice_t nxt   [VOICES];
  logic   hit   [VOICES];
  logic   found_c [VOICES+1];
  logic   hole_c  [VOICES+1];
  voice_t tail_in;

  logic              full, found, rd_ok, rd_hit, last_step;
  logic [TIME_W-1:0] evt_time;
  logic [3:0]        stop_slot;
  logic [OW-1:0]     count_o, removed_o;
  logic [CMP_W-1:0]  rslot_x, count_x, step_x;

  assign s_tready = (state == ST_IDLE);

  // chain of cells
  assign found_c[0] = 1'b0;
  assign hole_c[0]  = 1'b0;

  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    if (i == VOICES - 1) begin : g_tail
      assign nxt[i] = tail_in;
    end else begin : g_mid
      assign nxt[i] = cells[i+1];
    end

    pvt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load_sel  (count == CW'(i)),
      .next_in   (nxt[i]),
      .found_in  (found_c[i]),
      .hole_in   (hole_c[i]),
      .found_out (found_c[i+1]),
      .hole_out  (hole_c[i+1]),
      .hit       (hit[i]),
      .q         (cells[i])
    );
  end

  always_comb begin
    evt_time  = (req_now == '0) ? '0 : req_now + TIME_W'(1);
    full      = (count == FULL_COUNT);
    last_step = (step == LAST_STEP);
    rslot_x   = CMP_W'(req_rslot);
    count_x   = CMP_W'(count);
    step_x    = CMP_W'(step);
    rd_ok     = rslot_x < count_x;
    rd_hit    = rd_ok && (step_x == rslot_x);
    count_o   = OW'(count);
    removed_o = OW'(removed);
  end

  // outcome of the stop search along the chain
  always_comb begin
    found     = found_c[VOICES];
    stop_slot = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (hit[i]) stop_slot = stop_slot | 4'(i);
    end
  end

  always_comb begin
    ctrl.op             = op_sel;
    ctrl.fresh.valid    = 1'b1;
    ctrl.fresh.dead     = 1'b0;
    ctrl.fresh.held     = 1'b1;
    ctrl.fresh.start    = evt_time;
    ctrl.fresh.stop     = '0;
    ctrl.fresh.tone     = req_tone;
    ctrl.fresh.gain     = req_gain;
    ctrl.fresh.deadline = '0;
    ctrl.tone           = req_tone;
    ctrl.now            = req_now;
    ctrl.stop_stamp     = evt_time;
    ctrl.deadline       = req_now + TIME_W'(release_len);
  end

  // what enters the top cell on a shift
  always_comb begin
    unique case (ctrl.op)
      OP_EVICT:  tail_in = ctrl.fresh;
      OP_ROTATE: tail_in = cells[0];
      default:   tail_in = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    op_sel     = OP_HOLD;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (req_kind)
          KIND_PLAY: begin
            op_sel     = full ? OP_EVICT : OP_APPEND;
            state_next = ST_EMIT;
          end
          KIND_STOP: begin
            op_sel     = OP_STOP;
            state_next = ST_EMIT;
          end
          KIND_TICK: begin
            op_sel     = OP_MARK;
            state_next = ST_COMPACT;
          end
          KIND_READ: state_next = ST_ROTATE;
          default:   state_next = ST_EMIT;
        endcase
      end
      ST_COMPACT: begin
        op_sel = OP_COMPACT;
        if (last_step) state_next = ST_EMIT;
      end
      ST_ROTATE: begin
        op_sel = OP_ROTATE;
        if (last_step) state_next = ST_EMIT;
      end
      ST_EMIT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      step        <= '0;
      release_len <= REL_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) release_len <= cfg_wdata;

      if (s_tvalid && s_tready) begin
        req_kind  <= kind_t'(s_tuser);
        req_now   <= s_tdata[30:0];
        req_tone  <= s_tdata[54:31];
        req_gain  <= s_tdata[70:55];
        req_rslot <= s_tdata[74:71];
      end

      unique case (state)
        ST_EXEC: begin
          step      <= '0;
          removed   <= '0;
          res_start <= '0;
          res_stop  <= '0;
          res_tone  <= '0;
          res_gain  <= '0;
          unique case (req_kind)
            KIND_PLAY: begin
              res_status <= full ? STAT_ADD_EVICT : STAT_ADDED;
              res_slot   <= full ? SLOT_LAST : count_o[3:0];
              if (!full) count <= count + CW'(1);
            end
            KIND_STOP: begin
              res_status <= found ? STAT_STOPPED : STAT_NO_MATCH;
              res_slot   <= stop_slot;
            end
            KIND_TICK: begin
              res_status <= STAT_TICK_DONE;
              res_slot   <= '0;
            end
            KIND_READ: begin
              res_status <= rd_ok ? STAT_READ_OK : STAT_READ_EMPTY;
              res_slot   <= req_rslot;
            end
            default: res_status <= STAT_TICK_DONE;
          endcase
        end
        ST_COMPACT: begin
          step <= step + CW'(1);
          // one dead entry leaves the chain per cycle
          if (hole_c[VOICES]) begin
            removed <= removed + CW'(1);
            count   <= count - CW'(1);
          end
        end
        ST_ROTATE: begin
          step <= step + CW'(1);
          if (rd_hit) begin
            res_start <= cells[0].start;
            res_stop  <= cells[0].held ? STOP_HELD : {1'b0, cells[0].stop};
            res_tone  <= cells[0].tone;
            res_gain  <= cells[0].gain;
          end
        end
        default: ;
      endcase

      if (state == ST_EMIT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tuser  <= res_status;
        m_tdata  <= {3'b000, res_gain, res_tone, res_stop, res_start,
                     removed_o[4:0], count_o[4:0], res_slot};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("voice count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("request taken without starting execution");

  a_compact_dec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPACT && hole_c[VOICES]) |=> (count == $past(count) - CW'(1)))
    else $error("compaction step did not drop one entry");

  a_read_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROTATE) |=> $stable(count))
    else $error("voice count changed during read");

endmodule
